>>> hdl/lce_pkg.sv
// Shared types and constants for the line centroid error block.
package lce_pkg;

    localparam int ADDR_W = 3;

    localparam logic [0:0] REG_SCAN_ROW = 1'b0;
    localparam logic [0:0] REG_CENTER   = 1'b1;

    localparam logic [7:0] SCAN_ROW_RST = 8'd120;
    localparam logic [8:0] CENTER_RST   = 9'd160;
    localparam logic [7:0] LEVEL_MAX    = 8'd255;
    localparam logic [8:0] TALLY_MAX    = 9'd511;

    localparam logic signed [23:0] SUM_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] SUM_MIN = 24'sh800000;
    localparam logic signed [22:0] ERR_MAX = 23'sh3FFFFF;
    localparam logic signed [22:0] ERR_MIN = 23'sh400000;
    localparam logic [23:0] ERR_MAG_POS = 24'd4194303;
    localparam logic [23:0] ERR_MAG_NEG = 24'd4194304;

    localparam int DIV_STEPS = 24;

    typedef struct packed {
        logic       mode;
        logic [7:0] row;
        logic [8:0] column;
        logic [7:0] level;
        logic       frame_end;
    } t_pixel;

    typedef struct packed {
        logic signed [22:0] steer_error;
        logic               no_line;
        logic [8:0]         bright_count;
        logic [6:0]         used_threshold;
    } t_result;

    typedef struct packed {
        logic signed [23:0] sum;
        logic [8:0]         tally;
        logic [6:0]         threshold;
    } t_job;

    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic empty;
    } t_qctl;

endpackage

>>> hdl/lce_front.sv
// Pixel front end: calibration trackers, weighted sum and bright count.
module lce_front #(
    parameter int FRAME_WIDTH  = 320,
    parameter int FRAME_HEIGHT = 240
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  lce_pkg::t_pixel i_pix,
    input  logic [7:0]    i_scan_row,
    input  logic [8:0]    i_center,
    input  logic          i_full,
    output logic          o_push,
    output lce_pkg::t_job o_job
);

    logic [7:0]        r_min, n_min;
    logic [7:0]        r_max, n_max;
    logic [6:0]        r_thr, n_thr;
    logic signed [23:0] r_sum, n_sum;
    logic [8:0]        r_tally, n_tally;

    logic               w_accept;
    logic               w_inside;
    logic signed [9:0]  w_offset;
    logic signed [18:0] w_prod;
    logic signed [24:0] w_acc;
    logic signed [23:0] w_sum_upd;
    logic [8:0]         w_tally_upd;
    logic [7:0]         w_tmin, w_tmax, w_span;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && o_ready;
    assign w_inside = (32'(i_pix.row) < FRAME_HEIGHT) && (32'(i_pix.column) < FRAME_WIDTH);

    assign w_offset = $signed({1'b0, i_pix.column}) - $signed({1'b0, i_center});
    assign w_prod   = w_offset * $signed({1'b0, i_pix.level});
    assign w_acc    = {r_sum[23], r_sum} + {{6{w_prod[18]}}, w_prod};

    always_comb begin
        w_tmin = r_min;
        w_tmax = r_max;
        if (w_inside) begin
            if (i_pix.level > r_max) w_tmax = i_pix.level;
            if (i_pix.level < r_min) w_tmin = i_pix.level;
        end
        w_span = (w_tmax >= w_tmin) ? (w_tmax - w_tmin) : 8'd0;

        w_sum_upd   = r_sum;
        w_tally_upd = r_tally;
        if (w_inside && i_pix.row == i_scan_row) begin
            if (w_acc[24] != w_acc[23]) begin
                w_sum_upd = w_acc[24] ? lce_pkg::SUM_MIN : lce_pkg::SUM_MAX;
            end else begin
                w_sum_upd = w_acc[23:0];
            end
            if (i_pix.level > {1'b0, r_thr} && r_tally != lce_pkg::TALLY_MAX) begin
                w_tally_upd = r_tally + 9'd1;
            end
        end
    end

    always_comb begin
        n_min   = r_min;
        n_max   = r_max;
        n_thr   = r_thr;
        n_sum   = r_sum;
        n_tally = r_tally;
        o_push  = 1'b0;
        if (w_accept) begin
            if (!i_pix.mode) begin
                n_min = w_tmin;
                n_max = w_tmax;
                if (i_pix.frame_end) begin
                    n_thr = w_span[7:1];
                    n_min = lce_pkg::LEVEL_MAX;
                    n_max = 8'd0;
                end
            end else begin
                n_sum   = w_sum_upd;
                n_tally = w_tally_upd;
                if (i_pix.frame_end) begin
                    o_push  = 1'b1;
                    n_sum   = '0;
                    n_tally = '0;
                end
            end
        end
    end

    assign o_job.sum       = w_sum_upd;
    assign o_job.tally     = w_tally_upd;
    assign o_job.threshold = r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min   <= lce_pkg::LEVEL_MAX;
            r_max   <= 8'd0;
            r_thr   <= 7'd0;
            r_sum   <= '0;
            r_tally <= '0;
        end else begin
            r_min   <= n_min;
            r_max   <= n_max;
            r_thr   <= n_thr;
            r_sum   <= n_sum;
            r_tally <= n_tally;
        end
    end

endmodule

>>> hdl/lce_queue.sv
// Two-entry queue of finished frame totals between front and divider.
module lce_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lce_pkg::t_job i_job,
    input  logic          i_pop,
    output lce_pkg::t_job o_job,
    output lce_pkg::t_qctl o_ctl
);

    lce_pkg::t_job r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count, n_count;
    logic       w_full, w_empty, w_push, w_pop;

    assign w_full  = (r_count == 2'd2);
    assign w_empty = (r_count == 2'd0);
    assign w_push  = i_push && !w_full;
    assign w_pop   = i_pop && !w_empty;
    assign o_job   = r_mem[r_rptr];

    assign o_ctl.push  = w_push;
    assign o_ctl.pop   = w_pop;
    assign o_ctl.full  = w_full;
    assign o_ctl.empty = w_empty;

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) n_count = r_count + 2'd1;
        else if (!w_push && w_pop) n_count = r_count - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wptr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) r_wptr <= !r_wptr;
            if (w_pop) r_rptr <= !r_rptr;
            r_count <= n_count;
        end
    end

endmodule

>>> hdl/lce_div.sv
// Back end: serial signed divide, saturation and output register.
module lce_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lce_pkg::t_job   i_job,
    input  lce_pkg::t_qctl  i_qctl,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output lce_pkg::t_result o_res
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]  r_state;
    logic [4:0]  r_cnt;
    logic        r_neg;
    logic [23:0] r_quo;
    logic [8:0]  r_rem;
    logic [8:0]  r_div;
    logic [6:0]  r_thr;
    logic        r_out_valid;
    lce_pkg::t_result r_out;

    logic [9:0]  w_trial;
    logic        w_ge;
    logic [9:0]  w_diff;
    logic [23:0] w_negmag;
    logic signed [22:0] w_err;
    logic        w_load;
    lce_pkg::t_result w_res;

    assign o_pop   = (r_state == S_IDLE) && !i_qctl.empty;
    assign w_trial = {r_rem, r_quo[23]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_negmag = 24'd0 - r_quo;
    assign w_load  = (r_state == S_DONE) && (!r_out_valid || i_ready);

    always_comb begin
        if (r_neg) begin
            w_err = (r_quo > lce_pkg::ERR_MAG_NEG) ? lce_pkg::ERR_MIN : $signed(w_negmag[22:0]);
        end else begin
            w_err = (r_quo > lce_pkg::ERR_MAG_POS) ? lce_pkg::ERR_MAX : $signed(r_quo[22:0]);
        end
        w_res.no_line        = (r_div == 9'd0);
        w_res.steer_error    = w_res.no_line ? 23'sd0 : w_err;
        w_res.bright_count   = r_div;
        w_res.used_threshold = r_thr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= 5'd0;
        end else begin
            if (w_load) r_out_valid <= 1'b1;
            else if (o_valid && i_ready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (!i_qctl.empty) begin
                        r_cnt   <= 5'd0;
                        r_state <= (i_job.tally == 9'd0) ? S_DONE : S_DIV;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(lce_pkg::DIV_STEPS - 1)) r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_load) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_neg <= i_job.sum[23];
            r_quo <= i_job.sum[23] ? (24'd0 - i_job.sum) : i_job.sum;
            r_rem <= 9'd0;
            r_div <= i_job.tally;
            r_thr <= i_job.threshold;
        end else if (r_state == S_DIV) begin
            r_quo <= {r_quo[22:0], w_ge};
            r_rem <= w_ge ? w_diff[8:0] : w_trial[8:0];
        end
        if (w_load) r_out <= w_res;
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

>>> hdl/line_centroid_error_with_threshold.sv
// Top level of the line centroid steering error block.
//
// Pixel channel (i_in_valid / o_in_ready / i_in_data) takes one grey pixel
// beat per cycle. Mode 0 frames calibrate: the last pixel sets the brightness
// threshold to half the level span. Mode 1 frames weigh the scan row; the
// last pixel hands the frame totals to a two-entry queue.
// Result channel (o_out_valid / i_out_ready / o_out_data) gives one beat per
// measurement frame: the signed sum over the bright count, truncated toward
// zero and saturated, or zero with no_line when nothing was bright.
// The result comes from the 24-step one-bit-per-cycle divider, which an
// empty line skips. Pixels go in one per
// cycle; the pixel channel stalls only when the queue holds two frames,
// i.e. when results are not taken or frames are shorter than the divide.
// A stalled result waits in the output register while the divider and the
// front keep working. Reset clears trackers, sums, queue and output valid,
// and loads the scan row and center column defaults.
// Registers over APB: scan_row at 0x0, center_column at 0x4.
module line_centroid_error_with_threshold #(
    parameter int FRAME_WIDTH  = 320,
    parameter int FRAME_HEIGHT = 240
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  lce_pkg::t_pixel            i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output lce_pkg::t_result           o_out_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lce_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic [7:0] r_scan_row;
    logic [8:0] r_center;
    logic       w_wr;
    logic       w_push;
    logic       w_pop;
    lce_pkg::t_job  w_job_in, w_job_out;
    lce_pkg::t_qctl w_qctl;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign prdata = (paddr[2] == lce_pkg::REG_CENTER) ? {23'd0, r_center}
                                                      : {24'd0, r_scan_row};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_row <= lce_pkg::SCAN_ROW_RST;
            r_center   <= lce_pkg::CENTER_RST;
        end else if (w_wr) begin
            if (paddr[2] == lce_pkg::REG_SCAN_ROW) r_scan_row <= pwdata[7:0];
            else r_center <= pwdata[8:0];
        end
    end

    lce_front #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .o_ready    (o_in_ready),
        .i_pix      (i_in_data),
        .i_scan_row (r_scan_row),
        .i_center   (r_center),
        .i_full     (w_qctl.full),
        .o_push     (w_push),
        .o_job      (w_job_in)
    );

    lce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_ctl   (w_qctl)
    );

    lce_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (w_job_out),
        .i_qctl  (w_qctl),
        .o_pop   (w_pop),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (o_out_data)
    );

endmodule

>>> hdl/lce_checker.sv
// Port-level checks for the line centroid error block, with bind.
module lce_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input lce_pkg::t_pixel            i_in_data,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input lce_pkg::t_result           o_out_data,
    input logic                       psel,
    input logic                       penable,
    input logic                       pwrite,
    input logic [lce_pkg::ADDR_W-1:0] paddr,
    input logic [31:0]                pwdata,
    input logic [31:0]                prdata,
    input logic                       pready
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    a_no_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.no_line
        |-> o_out_data.steer_error == 23'sd0 && o_out_data.bright_count == 9'd0)
        else $error("no_line with nonzero error or count");

    a_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.no_line |-> o_out_data.bright_count != 9'd0)
        else $error("zero count without no_line");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel |-> pready)
        else $error("pready low");

endmodule

bind line_centroid_error_with_threshold lce_checker u_lce_checker (.*);
